// File: hw/rtl/ecdt_pkg.sv
`default_nettype none

package ecdt_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int EVENT_SLOTS_DEF = 256;

    // Field widths of one transfer on either channel.
    localparam int ACT_W   = 2;
    localparam int EVT_W   = 8;
    localparam int CHN_W   = 4;
    localparam int DLY_W   = 24;
    localparam int LRG_W   = 23;
    localparam int APP_W   = 24;
    localparam int USED_W  = 9;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;

    // Return factor registers, Q1.15.
    localparam int NUM_RET    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int RET_W      = 16;
    localparam logic [RET_W-1:0] RET_ONE = 16'd32768;

    localparam int PROD_W = RET_W + 1 + DLY_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_STORE = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_CLR,
        ALU_SCAN,
        ALU_MUL,
        ALU_RND
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic             mark_hit;
        logic             take_raw;
        logic [RET_W-1:0] keep;
    } alu_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/ecdt_ret_regs.sv
`default_nettype none

module ecdt_ret_regs
    import ecdt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [RET_W-1:0]     cfg_wdata,
    input  wire logic [2:0]           sel_ch,
    output logic      [RET_W-1:0]     keep
);

    logic [RET_W-1:0] ret_reg [NUM_RET];
    logic [RET_W-1:0] wr_val;

    // Factors above 1.0 are held at 1.0.
    assign wr_val = (cfg_wdata > RET_ONE) ? RET_ONE : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_RET; i++) begin
                ret_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            ret_reg[cfg_addr] <= wr_val;
        end
    end

    // Fraction of the raw delay that is taken off the largest delay.
    assign keep = RET_ONE - ret_reg[sel_ch];

endmodule

`default_nettype wire

// File: hw/rtl/ecdt_alu.sv
`default_nettype none

module ecdt_alu
    import ecdt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire alu_cmd_t                cmd,
    input  wire logic signed [DLY_W-1:0] rd_data,
    output logic             [LRG_W-1:0] largest,
    output logic signed      [DLY_W-1:0] raw,
    output logic             [APP_W-1:0] applied
);

    logic        [LRG_W-1:0]  top_reg;
    logic signed [DLY_W-1:0]  raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [APP_W-1:0]  app_reg;

    logic signed [PROD_W-1:0] blend;
    logic        [PROD_W-1:0] rounded;
    logic                     bigger;

    assign bigger = rd_data > $signed({1'b0, top_reg});

    // Blend at 15 fraction bits, floor at zero, round half up to 24 bits.
    assign blend   = $signed({3'b000, top_reg, 15'd0}) - prod_reg;
    assign rounded = (blend[PROD_W-1] ? '0 : $unsigned(blend)) + PROD_W'(16384);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            ALU_CLR: begin
                top_reg <= '0;
                raw_reg <= '0;
            end
            ALU_SCAN: begin
                if (cmd.mark_hit && bigger) begin
                    top_reg <= rd_data[LRG_W-1:0];
                end
                if (cmd.take_raw) begin
                    raw_reg <= rd_data;
                end
            end
            ALU_MUL: begin
                prod_reg <= $signed({1'b0, cmd.keep}) * raw_reg;
            end
            ALU_RND: begin
                if (|rounded[PROD_W-1:APP_W+15]) begin
                    app_reg <= '1;
                end else begin
                    app_reg <= rounded[APP_W+14:15];
                end
            end
            default: begin
            end
        endcase
    end

    assign largest = top_reg;
    assign raw     = raw_reg;
    assign applied = app_reg;

endmodule

`default_nettype wire

// File: hw/rtl/event_channel_delay_table.sv
`default_nettype none

// Channel   Ports                             Content
// --------  --------------------------------  ----------------------------------------
// input     s_tvalid/s_tready/s_tdata/s_tuser action in tuser; slot, channel, delay
// result    m_tvalid/m_tready/m_tdata         valid, raw, largest, applied, used count
// config    cfg_we/cfg_addr/cfg_wdata         return factor of channels 0 to 7
//
// Store and erase pass through a lookup and an update step before the result; a
// query reads one delay per channel through the shared compare unit, then takes
// one multiply and one rounding step. Clear sweeps every slot before its result.
// After reset a clearing pass over all EVENT_SLOTS rows runs before s_tready rises.
// A waiting result is held in the output register; the next transfer is
// accepted meanwhile, but its result waits until m_tready frees the register.

module event_channel_delay_table
    import ecdt_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int EVENT_SLOTS = EVENT_SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // event_index[7:0], channel_number[11:8], delay_value[35:12], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  wire logic [ACT_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // entry_valid[0], raw_delay[24:1], largest_delay[47:25],
    // applied_delay[71:48], used_events[80:72], zero fill
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [RET_W-1:0]     cfg_wdata
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = $clog2(EVENT_SLOTS);
    localparam int SXW   = (SW > EVT_W) ? SW : EVT_W;
    localparam int CNTW  = $clog2(EVENT_SLOTS + 1);
    localparam int DEPTH = EVENT_SLOTS * (2 ** CW);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK,
        ST_UPD,
        ST_SCAN,
        ST_MUL,
        ST_RND,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;
    action_t              act_reg, act_next;
    logic [EVT_W-1:0]     evt_reg, evt_next;
    logic [CHN_W-1:0]     chn_reg, chn_next;
    logic [DLY_W-1:0]     dly_reg, dly_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [SW-1:0]        sweep_reg, sweep_next;
    logic                 sresp_reg, sresp_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 mval_reg, mval_next;
    logic [M_TDATA_W-1:0] mdat_reg, mdat_next;

    logic [CHANNELS-1:0]  mark_mem [EVENT_SLOTS];
    logic [CHANNELS-1:0]  mark_q;
    logic                 mark_we;
    logic [SW-1:0]        mark_waddr;
    logic [CHANNELS-1:0]  mark_wdata;

    logic [DLY_W-1:0]     dly_mem [DEPTH];
    logic signed [DLY_W-1:0] dly_q;
    logic                 dly_we;

    logic [SXW-1:0]       slot_ext;
    logic [SW-1:0]        slot_idx;
    logic [CW-1:0]        ch_idx;
    logic                 slot_ok, ch_ok, hit, qry_ok;
    logic [RET_W-1:0]     keep;
    alu_cmd_t             cmd;
    logic [LRG_W-1:0]     alu_lrg;
    logic signed [DLY_W-1:0] alu_raw;
    logic [APP_W-1:0]     alu_app;

    assign slot_ext = SXW'(evt_reg);
    assign slot_idx = slot_ext[SW-1:0];
    // One extra bit so that a slot count of a full power of two still compares.
    assign slot_ok  = {1'b0, slot_ext} < (SXW+1)'(EVENT_SLOTS);
    assign ch_idx   = chn_reg[CW-1:0];
    assign ch_ok    = chn_reg < CHN_W'(CHANNELS);
    assign hit      = ch_ok && mark_q[ch_idx];
    assign qry_ok   = (act_reg == ACT_QUERY) && slot_ok;

    ecdt_ret_regs u_ret (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sel_ch    (chn_reg[2:0]),
        .keep      (keep)
    );

    ecdt_alu u_alu (
        .aclk    (aclk),
        .cmd     (cmd),
        .rd_data (dly_q),
        .largest (alu_lrg),
        .raw     (alu_raw),
        .applied (alu_app)
    );

    // Valid-mark rows, one bit per channel; a row is present when any bit is set.
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q <= mark_mem[slot_idx];
    end

    always_ff @(posedge aclk) begin
        if (dly_we) begin
            dly_mem[{slot_idx, ch_idx}] <= dly_reg;
        end
        dly_q <= $signed(dly_mem[{slot_idx, scan_next}]);
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        evt_next   = evt_reg;
        chn_next   = chn_reg;
        dly_next   = dly_reg;
        scan_next  = '0;
        sweep_next = sweep_reg;
        sresp_next = sresp_reg;
        cnt_next   = cnt_reg;
        mval_next  = mval_reg && !m_tready;
        mdat_next  = mdat_reg;
        mark_we    = 1'b0;
        mark_waddr = slot_idx;
        mark_wdata = '0;
        dly_we     = 1'b0;
        cmd.op       = ALU_NOP;
        cmd.mark_hit = mark_q[scan_reg];
        cmd.take_raw = ch_ok && mark_q[scan_reg] && (scan_reg == ch_idx);
        cmd.keep     = keep;

        unique case (state_reg)
            ST_SWEEP: begin
                mark_we    = 1'b1;
                mark_waddr = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SW'(EVENT_SLOTS - 1)) begin
                    sweep_next = '0;
                    state_next = sresp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = action_t'(s_tuser);
                    evt_next   = s_tdata[EVT_W-1:0];
                    chn_next   = s_tdata[EVT_W+CHN_W-1:EVT_W];
                    dly_next   = s_tdata[EVT_W+CHN_W+DLY_W-1:EVT_W+CHN_W];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.op = ALU_CLR;
                unique case (act_reg)
                    ACT_CLEAR: begin
                        cnt_next   = '0;
                        sweep_next = '0;
                        sresp_next = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    ACT_QUERY: begin
                        state_next = slot_ok ? ST_SCAN : ST_RESP;
                    end
                    default: begin
                        state_next = ST_UPD;
                    end
                endcase
            end
            ST_UPD: begin
                state_next = ST_RESP;
                if (act_reg == ACT_STORE) begin
                    if (slot_ok && ch_ok) begin
                        dly_we     = 1'b1;
                        mark_we    = 1'b1;
                        mark_wdata = mark_q | (CHANNELS'(1) << ch_idx);
                        if (mark_q == '0) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end else if (slot_ok && (mark_q != '0)) begin
                    mark_we  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SCAN: begin
                // dly_q holds the delay of channel scan_reg.
                cmd.op    = ALU_SCAN;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == CW'(CHANNELS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op     = ALU_MUL;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.op     = ALU_RND;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdat_next  = '0;
                    mdat_next[0]     = qry_ok && hit;
                    mdat_next[24:1]  = (qry_ok && hit) ? alu_raw : '0;
                    mdat_next[47:25] = qry_ok ? alu_lrg : '0;
                    mdat_next[71:48] = (qry_ok && hit) ? alu_app : '0;
                    mdat_next[80:72] = USED_W'(cnt_reg);
                    sresp_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            sresp_reg <= 1'b0;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
            scan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            sresp_reg <= sresp_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
            scan_reg  <= scan_next;
        end
        act_reg  <= act_next;
        evt_reg  <= evt_next;
        chn_reg  <= chn_next;
        dly_reg  <= dly_next;
        mdat_reg <= mdat_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(EVENT_SLOTS))
        else $error("row count above slot count");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[24:1] == '0) && (m_tdata[71:48] == '0))
        else $error("invalid entry reports a nonzero delay");
`endif

endmodule

`default_nettype wire

// File: verif/ecdt_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and return-factor write ports of the delay table.
// It keeps its own copy of the table, predicts the reply to every accepted
// input transfer and compares each result transfer with the oldest reply.
module ecdt_checker
    import ecdt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [RET_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   awaiting
);

    typedef struct packed {
        logic                    entry_valid;
        logic signed [DLY_W-1:0] raw_delay;
        logic [LRG_W-1:0]        largest_delay;
        logic [APP_W-1:0]        applied_delay;
        logic [USED_W-1:0]       used_events;
    } lookup_reply_t;

    logic signed [DLY_W-1:0] delay_mem [EVENT_SLOTS_DEF][CHANNELS_DEF];
    logic [CHANNELS_DEF-1:0] chan_marks [EVENT_SLOTS_DEF];
    logic                    row_used [EVENT_SLOTS_DEF];
    int unsigned             rows_held;
    logic [RET_W-1:0]        ret_factor [NUM_RET];
    lookup_reply_t           expected_replies [$];

    initial begin
        mismatches = 0;
        awaiting   = 0;
    end

    task automatic report_mismatch(string what, longint want, longint got);
        // Printing stops after a hundred lines so a broken block cannot flood the log.
        if (mismatches < 100)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic lookup_reply_t apply_table_action(action_t act, logic [EVT_W-1:0] slot,
                                                         logic [CHN_W-1:0] chan,
                                                         logic signed [DLY_W-1:0] dly);
        lookup_reply_t reply;
        longint        top;
        longint        keep;
        longint        blend;
        reply = '0;
        case (act)
            ACT_STORE: begin
                if (chan < CHANNELS_DEF) begin
                    delay_mem[slot][chan]  = dly;
                    chan_marks[slot][chan] = 1'b1;
                    if (!row_used[slot]) begin
                        row_used[slot] = 1'b1;
                        rows_held++;
                    end
                end
            end
            ACT_QUERY: begin
                top = 0;
                for (int c = 0; c < CHANNELS_DEF; c++)
                    if (chan_marks[slot][c] && delay_mem[slot][c] > top)
                        top = delay_mem[slot][c];
                reply.largest_delay = top[LRG_W-1:0];
                if (chan < CHANNELS_DEF && chan_marks[slot][chan]) begin
                    // Blend kept with 15 extra fraction bits, floored, then rounded half up.
                    keep  = longint'(RET_ONE) - longint'(ret_factor[chan]);
                    blend = top * longint'(RET_ONE) - keep * longint'(delay_mem[slot][chan]);
                    if (blend < 0)
                        blend = 0;
                    blend = (blend + 16384) >>> 15;
                    if (blend > 16777215)
                        blend = 16777215;
                    reply.entry_valid   = 1'b1;
                    reply.raw_delay     = delay_mem[slot][chan];
                    reply.applied_delay = blend[APP_W-1:0];
                end
            end
            ACT_ERASE: begin
                if (row_used[slot]) begin
                    row_used[slot]   = 1'b0;
                    chan_marks[slot] = '0;
                    rows_held--;
                end
            end
            default: begin
                for (int e = 0; e < EVENT_SLOTS_DEF; e++) begin
                    row_used[e]   = 1'b0;
                    chan_marks[e] = '0;
                end
                rows_held = 0;
            end
        endcase
        reply.used_events = rows_held[USED_W-1:0];
        return reply;
    endfunction

    always @(posedge aclk) begin
        lookup_reply_t got;
        lookup_reply_t want;
        if (!aresetn) begin
            for (int e = 0; e < EVENT_SLOTS_DEF; e++) begin
                row_used[e]   = 1'b0;
                chan_marks[e] = '0;
            end
            for (int r = 0; r < NUM_RET; r++)
                ret_factor[r] = '0;
            rows_held = 0;
            expected_replies.delete();
            awaiting <= 0;
        end else begin
            if (cfg_we)
                ret_factor[cfg_addr] = (cfg_wdata > RET_ONE) ? RET_ONE : cfg_wdata;
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_table_action(action_t'(s_tuser),
                    s_tdata[EVT_W-1:0], s_tdata[EVT_W+CHN_W-1:EVT_W],
                    s_tdata[EVT_W+CHN_W+DLY_W-1:EVT_W+CHN_W]));
            if (m_tvalid && m_tready) begin
                got.entry_valid   = m_tdata[0];
                got.raw_delay     = m_tdata[24:1];
                got.largest_delay = m_tdata[47:25];
                got.applied_delay = m_tdata[71:48];
                got.used_events   = m_tdata[80:72];
                if (expected_replies.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding", 0, 1);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.entry_valid != want.entry_valid)
                        report_mismatch("entry_valid", want.entry_valid, got.entry_valid);
                    if (got.raw_delay != want.raw_delay)
                        report_mismatch("raw_delay", want.raw_delay, got.raw_delay);
                    if (got.largest_delay != want.largest_delay)
                        report_mismatch("largest_delay", want.largest_delay, got.largest_delay);
                    if (got.applied_delay != want.applied_delay)
                        report_mismatch("applied_delay", want.applied_delay, got.applied_delay);
                    if (got.used_events != want.used_events)
                        report_mismatch("used_events", want.used_events, got.used_events);
                end
            end
            awaiting <= expected_replies.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ecdt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CHUNK_ITEMS  = 300;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    action_t              s_tuser   = ACT_STORE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [RET_W-1:0]     cfg_wdata = '0;
    int                   mismatches;
    int                   awaiting;
    int                   s_idle_pct = 0;
    int                   m_idle_pct = 0;
    int                   quiet_cycles = 0;

    event_channel_delay_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ecdt_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Leaves s_tvalid high after the transfer so back-to-back items need no extra step.
    task automatic send_action(action_t act, logic [EVT_W-1:0] slot, logic [CHN_W-1:0] chan,
                               logic [DLY_W-1:0] dly);
        if ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-DLY_W-CHN_W-EVT_W){1'b0}}, dly, chan, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
    endtask

    task automatic program_returns(int setting);
        logic [RET_W-1:0] val;
        for (int i = 0; i < NUM_RET; i++) begin
            case (setting)
                // Full return everywhere, partly through writes that must clamp.
                0:       val = (i % 3 == 0) ? RET_ONE : (i % 3 == 1) ? 16'hFFFF : RET_ONE + 16'd1;
                1:       val = 16'($urandom_range(32768));
                2:       val = '0;
                default: val = 16'($urandom);
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= val;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random();
        action_t          act;
        logic [EVT_W-1:0] slot;
        logic [CHN_W-1:0] chan;
        logic [DLY_W-1:0] dly;
        logic [31:0]      bits;
        int               pick;
        pick = $urandom_range(99);
        act  = (pick < 42) ? ACT_STORE : (pick < 88) ? ACT_QUERY :
               (pick < 98) ? ACT_ERASE : ACT_CLEAR;
        // A small pool of slots keeps rows filling up so queries mostly find entries.
        slot = ($urandom_range(9) < 8) ? EVT_W'($urandom_range(11)) : EVT_W'($urandom);
        chan = ($urandom_range(9) < 9) ? CHN_W'($urandom_range(CHANNELS_DEF - 1))
                                       : CHN_W'($urandom_range(15, CHANNELS_DEF));
        bits = $urandom;
        pick = $urandom_range(9);
        if (pick < 4)
            dly = {{(DLY_W-12){bits[11]}}, bits[11:0]};
        else if (pick < 6)
            case (bits[1:0])
                2'd0:    dly = 24'h7FFFFF;
                2'd1:    dly = 24'h800000;
                2'd2:    dly = 24'h000000;
                default: dly = 24'h000080;
            endcase
        else
            dly = bits[DLY_W-1:0];
        send_action(act, slot, chan, dly);
    endtask

    initial begin
        s_idle_pct = 11;
        m_idle_pct = 53;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with every return factor still at its reset value of zero.
        send_action(ACT_QUERY, 8'd0, 4'd0, 24'h000000);
        send_action(ACT_STORE, 8'd0, 4'd0, 24'h7FFFFF);
        send_action(ACT_STORE, 8'd0, 4'd7, 24'h800000);
        send_action(ACT_STORE, 8'd0, 4'd15, 24'h000100);
        send_action(ACT_QUERY, 8'd0, 4'd0, 24'hFFFFFF);
        send_action(ACT_QUERY, 8'd0, 4'd7, 24'h000000);
        send_action(ACT_QUERY, 8'd0, 4'd15, 24'h000000);
        send_action(ACT_QUERY, 8'd0, 4'd3, 24'h000000);
        send_action(ACT_STORE, 8'd255, 4'd3, 24'hFFFF00);
        send_action(ACT_STORE, 8'd255, 4'd5, 24'hFFFFFF);
        send_action(ACT_QUERY, 8'd255, 4'd3, 24'h000000);
        send_action(ACT_QUERY, 8'd255, 4'd5, 24'h000000);
        send_action(ACT_STORE, 8'd255, 4'd5, 24'h000080);
        send_action(ACT_QUERY, 8'd255, 4'd5, 24'h000000);
        send_action(ACT_ERASE, 8'd0, 4'd0, 24'h000000);
        send_action(ACT_ERASE, 8'd0, 4'd0, 24'h000000);
        send_action(ACT_QUERY, 8'd0, 4'd0, 24'h000000);
        send_action(ACT_STORE, 8'd170, 4'd10, 24'hAAAAAA);
        send_action(ACT_STORE, 8'd85, 4'd2, 24'h555555);
        send_action(ACT_QUERY, 8'd85, 4'd2, 24'h000000);
        send_action(ACT_QUERY, 8'd170, 4'd10, 24'h000000);
        send_action(ACT_CLEAR, 8'd0, 4'd0, 24'h000000);
        send_action(ACT_QUERY, 8'd255, 4'd5, 24'h000000);
        send_action(ACT_STORE, 8'd1, 4'd1, 24'h000001);
        send_action(ACT_QUERY, 8'd1, 4'd1, 24'h000000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Each chunk starts from a drained block with a new set of return factors.
            if (n % CHUNK_ITEMS == 0) begin
                wait_drained();
                program_returns(n / CHUNK_ITEMS);
            end else if ($urandom_range(199) == 0) begin
                wait_drained();
            end
            if (n < RANDOM_ITEMS / 3) begin
                s_idle_pct = 11;
                m_idle_pct = 53;
            end else if (n < 2 * RANDOM_ITEMS / 3) begin
                s_idle_pct = 53;
                m_idle_pct = 11;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            send_random();
        end

        wait_drained();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
